@@ src/i2rd_pkg.sv @@
// shared types, constants and helper functions for the radix digit converter
`default_nettype none

package i2rd_pkg;

	// fixed field widths
	localparam int unsigned VALUE_IN_W = 64;
	localparam int unsigned RADIX_W    = 6;
	localparam int unsigned CHAR_W     = 7;

	// radix limits and reset value
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	// ascii anchors
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;
	localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_STORE,
		ST_READ,
		ST_EMIT
	} i2rd_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic store;
		logic read;
		logic emit;
	} i2rd_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic div_last;
		logic quot_zero;
		logic digits_full;
		logic read_last;
	} i2rd_status_t;

	// saturate the radix register to the supported bases
	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

	// digit value to ascii character
	function automatic logic [CHAR_W-1:0] to_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d < DEC_DIGITS) begin
			res = ASCII_ZERO + {1'b0, d};
		end else begin
			res = ASCII_A + {1'b0, d} - {1'b0, DEC_DIGITS};
		end
		return res;
	endfunction

endpackage

`default_nettype wire

@@ src/i2rd_ctrl.sv @@
// controller state machine sequencing division, digit store and emission
`default_nettype none

module i2rd_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire i2rd_pkg::i2rd_status_t st,
	output i2rd_pkg::i2rd_cmd_t        cmd,
	output logic                       busy
);
	import i2rd_pkg::*;

	i2rd_state_t state_q;
	i2rd_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				if (st.quot_zero || st.digits_full) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (st.read_last) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

@@ src/i2rd_dpath.sv @@
// datapath: radix register, bit-serial divider, digit memory and read pointer
`default_nettype none

module i2rd_dpath #(
	parameter int unsigned VALUE_WIDTH = 64,
	parameter int unsigned MAX_DIGITS  = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  radix_we,
	input  wire logic [i2rd_pkg::RADIX_W-1:0]          radix_wdata,
	input  wire logic [i2rd_pkg::VALUE_IN_W-1:0]       value,
	input  wire i2rd_pkg::i2rd_cmd_t                   cmd,
	output i2rd_pkg::i2rd_status_t                     st,
	output logic [i2rd_pkg::CHAR_W-1:0]                digit_char
);
	import i2rd_pkg::*;

	localparam int unsigned BIT_W = $clog2(VALUE_WIDTH);
	localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
	localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

	logic [RADIX_W-1:0]     radix_q;
	logic [RADIX_W-1:0]     base_q;
	logic [VALUE_WIDTH-1:0] quot_q;
	logic [RADIX_W-1:0]     rem_q;
	logic [BIT_W-1:0]       bit_cnt_q;
	logic [CNT_W-1:0]       n_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic [RADIX_W-1:0]     rd_data_q;
	logic [RADIX_W-1:0]     mem [MAX_DIGITS];

	logic [RADIX_W:0]       shifted;
	logic [RADIX_W:0]       diff;
	logic                   q_bit;

	// radix configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix_wdata;
		end
	end

	// one restoring division step: shift in the next dividend bit, trial subtract
	assign shifted = {rem_q, quot_q[VALUE_WIDTH-1]};
	assign diff    = shifted - {1'b0, base_q};
	assign q_bit   = (shifted >= {1'b0, base_q});

	// step and digit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			n_q       <= '0;
		end else begin
			if (cmd.load) begin
				bit_cnt_q <= '0;
				n_q       <= '0;
			end else if (cmd.div_step) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end else if (cmd.store) begin
				bit_cnt_q <= '0;
				n_q       <= n_q + 1'b1;
			end
		end
	end

	// dividend, quotient, remainder and read pointer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= clamp_radix(radix_q);
			quot_q <= value[VALUE_WIDTH-1:0];
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[VALUE_WIDTH-2:0], q_bit};
			rem_q  <= q_bit ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
		end else if (cmd.store) begin
			rem_q    <= '0;
			rd_idx_q <= n_q[IDX_W-1:0];
		end else if (cmd.emit) begin
			rd_idx_q <= rd_idx_q - 1'b1;
		end
	end

	// digit memory, least significant digit in entry zero
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[n_q[IDX_W-1:0]] <= rem_q;
		end
		if (cmd.read) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	// status back to the controller
	assign st.div_last    = (bit_cnt_q == BIT_W'(VALUE_WIDTH - 1));
	assign st.quot_zero   = (quot_q == '0);
	assign st.digits_full = (n_q == CNT_W'(MAX_DIGITS - 1));
	assign st.read_last   = (rd_idx_q == '0);

	assign digit_char = to_ascii(rd_data_q);

endmodule

`default_nettype wire

@@ src/integer_to_radix_digits_core.sv @@
// top level of the integer to radix digit string converter
// Usage:
//   Set the radix with radix_we/radix_wdata while the block is idle; values
//   outside 2..36 saturate to the nearest supported base. Reset gives radix 10.
//   A request is taken on a rising edge where start is high and busy is low.
//   The low VALUE_WIDTH bits of value are divided by the radix again and
//   again, one quotient bit per cycle in a shared restoring divider, with a
//   store step after each digit; up to MAX_DIGITS digits are kept.
//   The digits are then read back from a small memory most significant first
//   and shown on digit_char, one memory read before each digit_valid strobe;
//   digit_valid is high for one cycle per digit and last_digit marks the
//   least significant one. Zero gives '0'. A request keeps busy high until
//   its last digit is shown, and the first digit appears only after all
//   digits have been found. The receiver cannot stall: every strobed digit
//   must be taken. Reset is asynchronous and returns the controller to idle
//   at once.
`default_nettype none

module integer_to_radix_digits_core #(
	parameter int unsigned VALUE_WIDTH = 64,
	parameter int unsigned MAX_DIGITS  = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              radix_we,
	input  wire logic [i2rd_pkg::RADIX_W-1:0]      radix_wdata,
	input  wire logic                              start,
	input  wire logic [i2rd_pkg::VALUE_IN_W-1:0]   value,
	output logic                                   busy,
	output logic                                   digit_valid,
	output logic [i2rd_pkg::CHAR_W-1:0]            digit_char,
	output logic                                   last_digit
);
	import i2rd_pkg::*;

	i2rd_cmd_t    cmd;
	i2rd_status_t st;

	// sequencing
	i2rd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	// arithmetic and digit storage
	i2rd_dpath #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.value       (value),
		.cmd         (cmd),
		.st          (st),
		.digit_char  (digit_char)
	);

	// result strobe and final digit flag
	assign digit_valid = cmd.emit;
	assign last_digit  = cmd.emit & st.read_last;

endmodule

`default_nettype wire

@@ src/i2rd_checker.sv @@
// port-level checks for the radix digit converter and their binding
`default_nettype none

module i2rd_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         digit_valid,
	input wire logic [i2rd_pkg::CHAR_W-1:0]  digit_char,
	input wire logic                         last_digit
);

	// a digit only appears while a request is in progress
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> busy)
		else $error("digit strobe outside a request");

	// an accepted request makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// the final digit ends the request
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(digit_valid && last_digit) |=> !busy)
		else $error("block still busy after final digit");

	// a digit strobe is never followed directly by another
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |=> !digit_valid)
		else $error("digits on consecutive cycles");

	// every digit is a legal character
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> ((digit_char >= 7'd48 && digit_char <= 7'd57) ||
			(digit_char >= 7'd65 && digit_char <= 7'd90)))
		else $error("digit character out of range");

endmodule

bind integer_to_radix_digits_core i2rd_checker u_i2rd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.digit_valid (digit_valid),
	.digit_char  (digit_char),
	.last_digit  (last_digit)
);

`default_nettype wire
